// ----- src/ift_pkg.sv -----
// Shared types, codes and helper functions for the IPv4 flow tracker.
// Depends on nothing; the files that use it refer to it by scoped names.
package ift_pkg;

    localparam int FLOW_DEPTH_DEFAULT = 4096;

    localparam logic [1:0] STATUS_EXISTING  = 2'd0;
    localparam logic [1:0] STATUS_NEW       = 2'd1;
    localparam logic [1:0] STATUS_MALFORMED = 2'd2;
    localparam logic [1:0] STATUS_FULL      = 2'd3;

    localparam logic [1:0] CLASS_INT_INT = 2'd0;
    localparam logic [1:0] CLASS_INT_EXT = 2'd1;
    localparam logic [1:0] CLASS_EXT_EXT = 2'd2;

    localparam logic [7:0] PROTO_TCP = 8'd6;
    localparam logic [7:0] PROTO_UDP = 8'd17;

    localparam logic [15:0] MIN_IP_BYTES  = 16'd20;
    localparam logic [15:0] MIN_TCP_BYTES = 16'd20;
    localparam logic [15:0] MIN_UDP_BYTES = 16'd8;

    localparam logic [12:0] FLOWS_MAX   = 13'h1FFF;
    localparam logic [47:0] PACKETS_MAX = {48{1'b1}};
    localparam logic [55:0] BYTES_MAX   = {56{1'b1}};

    typedef struct packed {
        logic        bad;
        logic [7:0]  proto;
        logic [31:0] lo_addr;
        logic [31:0] hi_addr;
        logic [15:0] lo_port;
        logic [15:0] hi_port;
        logic [1:0]  cls;
        logic [15:0] frame;
    } item_t;

    // RFC1918 private ranges: 10/8, 172.16/12 and 192.168/16.
    function automatic logic addr_internal(input logic [31:0] a);
        return (a[31:24] == 8'd10) || (a[31:20] == 12'hAC1) || (a[31:16] == 16'hC0A8);
    endfunction

    function automatic logic [1:0] class_of(input logic [31:0] lo, input logic [31:0] hi);
        logic a;
        logic b;
        a = addr_internal(lo);
        b = addr_internal(hi);
        if (a && b) begin
            return CLASS_INT_INT;
        end else if (a || b) begin
            return CLASS_INT_EXT;
        end
        return CLASS_EXT_EXT;
    endfunction

endpackage

// ----- src/ift_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ift_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- src/ift_front.sv -----
// Front end: checks the header, orders the five-tuple and classes the flow.
// Depends on ift_pkg.
module ift_front (
    input  logic [15:0]     ip_bytes,
    input  logic [3:0]      header_words,
    input  logic [15:0]     total_length,
    input  logic [12:0]     frag_offset,
    input  logic [7:0]      ip_protocol,
    input  logic [31:0]     src_addr,
    input  logic [31:0]     dst_addr,
    input  logic [15:0]     src_port,
    input  logic [15:0]     dst_port,
    input  logic [15:0]     frame_bytes,
    output ift_pkg::item_t  item
);
    logic [15:0] hdr_len;
    logic [15:0] l4_len;
    logic        has_ports;
    logic        src_lower;

    always_comb begin
        hdr_len   = {10'b0, header_words, 2'b00};
        l4_len    = total_length - hdr_len;
        has_ports = (total_length >= hdr_len) &&
                    (((ip_protocol == ift_pkg::PROTO_TCP) && (l4_len >= ift_pkg::MIN_TCP_BYTES)) ||
                     ((ip_protocol == ift_pkg::PROTO_UDP) && (l4_len >= ift_pkg::MIN_UDP_BYTES)));
        src_lower = src_addr < dst_addr;

        item.bad   = (ip_bytes < ift_pkg::MIN_IP_BYTES) || (hdr_len > ip_bytes) ||
                     (ip_bytes < total_length) || (frag_offset != 13'd0);
        item.proto = ip_protocol;
        // Equal addresses take the destination as the lower side.
        item.lo_addr = src_lower ? src_addr : dst_addr;
        item.hi_addr = src_lower ? dst_addr : src_addr;
        item.lo_port = has_ports ? (src_lower ? src_port : dst_port) : 16'd0;
        item.hi_port = has_ports ? (src_lower ? dst_port : src_port) : 16'd0;
        item.cls     = ift_pkg::class_of(item.lo_addr, item.hi_addr);
        item.frame   = frame_bytes;
    end
endmodule

// ----- src/ift_queue.sv -----
// Two-entry queue of classified requests between the front and back ends.
// Depends on ift_pkg.
module ift_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  ift_pkg::item_t push_item,
    output logic           full,
    input  logic           pop,
    output logic           not_empty,
    output ift_pkg::item_t pop_item
);
    ift_pkg::item_t slot_reg [2];
    logic           wptr_reg;
    logic           rptr_reg;
    logic [1:0]     count_reg;
    logic [1:0]     count_next;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign pop_item  = slot_reg[rptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end else begin
            if (push) begin
                wptr_reg <= ~wptr_reg;
            end
            if (pop) begin
                rptr_reg <= ~rptr_reg;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wptr_reg] <= push_item;
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (!full || pop))
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> not_empty)
        else $error("queue read while empty");
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != 2'd3)
        else $error("queue count out of range");
`endif
endmodule

// ----- src/ift_back.sv -----
// Back end: searches the flow table, appends new flows, keeps the class
// counters and holds the result register. Depends on ift_pkg and ift_ram.
module ift_back #(
    parameter int FLOW_DEPTH = ift_pkg::FLOW_DEPTH_DEFAULT
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           q_valid,
    input  ift_pkg::item_t q_item,
    output logic           q_pop,
    output logic           m_valid,
    input  logic           m_ready,
    output logic [1:0]     m_status,
    output logic [11:0]    m_flow_index,
    output logic [1:0]     m_flow_class,
    output logic [12:0]    m_class_flows,
    output logic [47:0]    m_class_packets,
    output logic [55:0]    m_class_bytes
);
    localparam int IDX_W = (FLOW_DEPTH > 1) ? $clog2(FLOW_DEPTH) : 1;
    localparam int CNT_W = $clog2(FLOW_DEPTH + 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_READ = 3'd1;
    localparam logic [2:0] ST_CMP  = 3'd2;
    localparam logic [2:0] ST_UPD  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0]       state_reg;
    ift_pkg::item_t   item_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [CNT_W-1:0] used_reg;
    logic [1:0]       mode_reg;
    logic [1:0]       cls_reg;

    logic [12:0] flows_reg   [3];
    logic [47:0] packets_reg [3];
    logic [55:0] bytes_reg   [3];

    logic [1:0]  status_reg;
    logic [11:0] index_reg;
    logic [1:0]  class_reg;
    logic [12:0] cflows_reg;
    logic [47:0] cpackets_reg;
    logic [55:0] cbytes_reg;

    logic [63:0] rd_addr;
    logic [41:0] rd_key;
    logic        ram_we;
    logic        match;
    logic        last;
    logic        full;
    logic [CNT_W:0] idx_plus;
    logic [1:0]  hit_cls;

    logic [12:0] flows_next;
    logic [47:0] packets_next;
    logic [55:0] bytes_next;
    logic [56:0] bytes_sum;
    logic [IDX_W+11:0] index_wide;

    ift_ram #(.WIDTH(64), .DEPTH(FLOW_DEPTH)) u_addr_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (used_reg[IDX_W-1:0]),
        .wdata ({item_reg.lo_addr, item_reg.hi_addr}),
        .raddr (idx_reg),
        .rdata (rd_addr)
    );

    ift_ram #(.WIDTH(42), .DEPTH(FLOW_DEPTH)) u_key_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (used_reg[IDX_W-1:0]),
        .wdata ({item_reg.proto, item_reg.lo_port, item_reg.hi_port, cls_reg}),
        .raddr (idx_reg),
        .rdata (rd_key)
    );

    assign m_valid         = (state_reg == ST_OUT);
    assign m_status        = status_reg;
    assign m_flow_index    = index_reg;
    assign m_flow_class    = class_reg;
    assign m_class_flows   = cflows_reg;
    assign m_class_packets = cpackets_reg;
    assign m_class_bytes   = cbytes_reg;

    assign q_pop  = (state_reg == ST_IDLE) && q_valid;
    assign ram_we = (state_reg == ST_UPD) && (mode_reg == ift_pkg::STATUS_NEW);

    always_comb begin
        match    = (rd_addr == {item_reg.lo_addr, item_reg.hi_addr}) &&
                   (rd_key[41:2] == {item_reg.proto, item_reg.lo_port, item_reg.hi_port});
        idx_plus = (CNT_W + 1)'(idx_reg) + 1'b1;
        last     = (idx_plus == {1'b0, used_reg});
        full     = (used_reg == CNT_W'(FLOW_DEPTH));
        // A stored class code of three counts as external-external.
        hit_cls  = (rd_key[1:0] == 2'd3) ? ift_pkg::CLASS_EXT_EXT : rd_key[1:0];

        flows_next   = flows_reg[cls_reg];
        if ((mode_reg == ift_pkg::STATUS_NEW) && (flows_next != ift_pkg::FLOWS_MAX)) begin
            flows_next = flows_next + 13'd1;
        end
        packets_next = packets_reg[cls_reg];
        bytes_sum    = {1'b0, bytes_reg[cls_reg]} + {41'b0, item_reg.frame};
        bytes_next   = bytes_sum[56] ? ift_pkg::BYTES_MAX : bytes_sum[55:0];
        if (mode_reg == ift_pkg::STATUS_FULL) begin
            bytes_next = bytes_reg[cls_reg];
        end else if (packets_next != ift_pkg::PACKETS_MAX) begin
            packets_next = packets_next + 48'd1;
        end

        index_wide = '0;
        if (mode_reg == ift_pkg::STATUS_EXISTING) begin
            index_wide = {12'b0, idx_reg};
        end else if (mode_reg == ift_pkg::STATUS_NEW) begin
            index_wide = {12'b0, used_reg[IDX_W-1:0]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            used_reg  <= '0;
            idx_reg   <= '0;
            mode_reg  <= ift_pkg::STATUS_EXISTING;
            cls_reg   <= ift_pkg::CLASS_INT_INT;
            for (int c = 0; c < 3; c++) begin
                flows_reg[c]   <= '0;
                packets_reg[c] <= '0;
                bytes_reg[c]   <= '0;
            end
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (q_valid) begin
                        item_reg <= q_item;
                        cls_reg  <= q_item.cls;
                        idx_reg  <= '0;
                        if (q_item.bad) begin
                            status_reg   <= ift_pkg::STATUS_MALFORMED;
                            index_reg    <= '0;
                            class_reg    <= ift_pkg::CLASS_INT_INT;
                            cflows_reg   <= '0;
                            cpackets_reg <= '0;
                            cbytes_reg   <= '0;
                            state_reg    <= ST_OUT;
                        end else if (used_reg == '0) begin
                            mode_reg  <= ift_pkg::STATUS_NEW;
                            state_reg <= ST_UPD;
                        end else begin
                            state_reg <= ST_READ;
                        end
                    end
                end
                ST_READ: begin
                    state_reg <= ST_CMP;
                end
                ST_CMP: begin
                    if (match) begin
                        mode_reg  <= ift_pkg::STATUS_EXISTING;
                        cls_reg   <= hit_cls;
                        state_reg <= ST_UPD;
                    end else if (last) begin
                        mode_reg  <= full ? ift_pkg::STATUS_FULL : ift_pkg::STATUS_NEW;
                        state_reg <= ST_UPD;
                    end else begin
                        idx_reg   <= idx_plus[IDX_W-1:0];
                        state_reg <= ST_READ;
                    end
                end
                ST_UPD: begin
                    flows_reg[cls_reg]   <= flows_next;
                    packets_reg[cls_reg] <= packets_next;
                    bytes_reg[cls_reg]   <= bytes_next;
                    if (mode_reg == ift_pkg::STATUS_NEW) begin
                        used_reg <= used_reg + 1'b1;
                    end
                    status_reg   <= mode_reg;
                    index_reg    <= index_wide[11:0];
                    class_reg    <= cls_reg;
                    cflows_reg   <= flows_next;
                    cpackets_reg <= packets_next;
                    cbytes_reg   <= bytes_next;
                    state_reg    <= ST_OUT;
                end
                ST_OUT: begin
                    if (m_ready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_used_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        used_reg <= CNT_W'(FLOW_DEPTH))
        else $error("flow table count beyond its depth");
    a_full_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> !full)
        else $error("append while table full");
    a_full_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status == ift_pkg::STATUS_FULL)) |-> (m_flow_index == 12'd0))
        else $error("full result carries a flow index");
    a_append_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |=> (used_reg == $past(used_reg) + 1'b1))
        else $error("append did not advance the count");
`endif
endmodule

// ----- src/ipv4_flow_tracker.sv -----
// IPv4 five-tuple flow tracker with per-class saturating counters.
// Depends on ift_pkg, ift_front, ift_queue, ift_back and ift_ram.
//
// Usage: the s_ channel takes one request per packet (header fields and
// frame length) with valid/ready; the m_ channel returns exactly one result
// per request, in order, with valid/ready. Results carry the status
// (existing, new, malformed, table full), the flow entry, its class and the
// flow, packet and byte counts of that class after the update (zeros if malformed).
// A malformed request goes from the queue straight to the result register;
// a tracked request passes one RAM read state and one compare state for
// each table entry compared, then the update state, and goes straight to
// the update state while the table is empty. The search engine takes the
// next request from the queue only after the result is taken; the linear
// table search, which reads one entry at a time, sets the rate.
// A two-entry queue sits behind the input, so up to two further requests
// are taken while a result waits. When the receiver holds m_ready low the
// result stays registered and the search engine waits; s_ready falls once
// the queue is full.
// Reset (aresetn low, synchronous) empties the table and queue and clears
// all class counters; no clearing pass is needed.
module ipv4_flow_tracker #(
    parameter int FLOW_DEPTH = ift_pkg::FLOW_DEPTH_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_ip_bytes,
    input  logic [3:0]  s_header_words,
    input  logic [15:0] s_total_length,
    input  logic [12:0] s_frag_offset,
    input  logic [7:0]  s_ip_protocol,
    input  logic [31:0] s_src_addr,
    input  logic [31:0] s_dst_addr,
    input  logic [15:0] s_src_port,
    input  logic [15:0] s_dst_port,
    input  logic [15:0] s_frame_bytes,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [11:0] m_flow_index,
    output logic [1:0]  m_flow_class,
    output logic [12:0] m_class_flows,
    output logic [47:0] m_class_packets,
    output logic [55:0] m_class_bytes
);
    ift_pkg::item_t front_item;
    ift_pkg::item_t q_item;
    logic           q_full;
    logic           q_valid;
    logic           q_pop;

    assign s_ready = !q_full;

    ift_front u_front (
        .ip_bytes     (s_ip_bytes),
        .header_words (s_header_words),
        .total_length (s_total_length),
        .frag_offset  (s_frag_offset),
        .ip_protocol  (s_ip_protocol),
        .src_addr     (s_src_addr),
        .dst_addr     (s_dst_addr),
        .src_port     (s_src_port),
        .dst_port     (s_dst_port),
        .frame_bytes  (s_frame_bytes),
        .item         (front_item)
    );

    ift_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s_valid && s_ready),
        .push_item (front_item),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .pop_item  (q_item)
    );

    ift_back #(.FLOW_DEPTH(FLOW_DEPTH)) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .q_valid         (q_valid),
        .q_item          (q_item),
        .q_pop           (q_pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_flow_index    (m_flow_index),
        .m_flow_class    (m_flow_class),
        .m_class_flows   (m_class_flows),
        .m_class_packets (m_class_packets),
        .m_class_bytes   (m_class_bytes)
    );
endmodule
